// ----- design/ffca_pkg.sv -----
package ffca_pkg;
  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam logic [31:0] PageBytes = 32'd4096;
  localparam int PageShift = $clog2(PageBytes);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_POOL_BASE = 2'd0,
    REG_POOL_SIZE = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PREV_RD,
    S_PREV_CHK,
    S_MERGE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_chk;
    logic prev_rd;
    logic prev_chk;
    logic merge;
    logic shift_rd;
    logic shift_wr;
    logic finish;
  } ctrl_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic    reject;
    logic    is_alloc;
    logic    scan_end;
    logic    hit;
    logic    has_prev;
    logic    need_shift;
    logic    shift_end;
  } stat_t;

  function automatic logic [31:0] round_page(input logic [31:0] sz);
    logic [32:0] s;
    s = {1'b0, sz} + {1'b0, PageBytes} - 33'd1;
    return {s[31:PageShift], {PageShift{1'b0}}};
  endfunction
endpackage

// ----- design/first_fit_coalescing_allocator_top.sv -----
// First-fit free-region allocator with merging of neighbors. One command is
// processed at a time, and in_stall holds off new commands until the block is
// idle again; a finished command can wait on out_stall. Every table read is
// registered on the region memory, which has one read and one write port.
module first_fit_coalescing_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] req_size,
  input  logic [31:0] req_address,
  input  logic        round_to_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] granted_address,
  output logic [31:0] free_total,
  output logic [6:0]  free_entries
);
  import ffca_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ffca_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .ctrl);

  ffca_datapath u_dp (
    .clk, .rst, .ctrl, .stat, .cfg_valid, .cfg_index, .cfg_data,
    .cmd, .req_size, .req_address, .round_to_page,
    .status, .granted_address, .free_total, .free_entries);
endmodule

// ----- design/ffca_ram.sv -----
module ffca_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/ffca_datapath.sv -----
module ffca_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  ffca_pkg::ctrl_t        ctrl,
  output ffca_pkg::stat_t        stat,
  input  logic                   cfg_valid,
  input  logic [0:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic [1:0]             cmd,
  input  logic [31:0]            req_size,
  input  logic [31:0]            req_address,
  input  logic                   round_to_page,
  output logic [1:0]             status,
  output logic [31:0]            granted_address,
  output logic [31:0]            free_total,
  output logic [6:0]             free_entries
);
  import ffca_pkg::*;

  logic [31:0] pool_base, pool_size;
  logic [1:0]  op;
  logic [31:0] size, addr;
  logic [CntW-1:0] count;
  logic [31:0] fsum;
  logic [CntW-1:0] idx;      // scan position
  logic [CntW-1:0] sidx;     // shift position
  logic [31:0] cur_start, cur_size, prev_start, prev_size;
  logic        prev_adj, next_adj, hit;
  logic [1:0]  res_status;
  logic [31:0] res_grant;

  logic           we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0]    wstart, wsize, rstart, rsize;

  ffca_ram #(.Width(32), .Depth(TableEntries)) u_start (
    .clk, .we, .waddr, .wdata(wstart), .raddr, .rdata(rstart));
  ffca_ram #(.Width(32), .Depth(TableEntries)) u_size (
    .clk, .we, .waddr, .wdata(wsize), .raddr, .rdata(rsize));

  logic [31:0] sz_in;
  logic        in_zero;
  always_comb begin
    sz_in = (round_to_page && cmd != CMD_INIT) ? round_page(req_size) : req_size;
    case (cmd)
      CMD_ALLOC: in_zero = (sz_in == 32'd0);
      CMD_FREE:  in_zero = (sz_in == 32'd0) || (req_address == 32'd0);
      CMD_INIT:  in_zero = (pool_size == 32'd0) || (pool_base == 32'd0);
      default:   in_zero = 1'b1;
    endcase
  end

  logic merge_prev_only, merge_both, merge_next;
  always_comb begin
    next_adj = (idx < count) && (cur_start == addr + size);
    merge_both = prev_adj && next_adj;
    merge_prev_only = prev_adj && !next_adj;
    merge_next = !prev_adj && next_adj;
  end

  // Found-entry test during the scan.
  logic scan_stop;
  always_comb begin
    if (op == CMD_ALLOC) scan_stop = (rsize >= size);
    else                 scan_stop = (rstart > addr);
  end

  always_comb begin
    stat.reject     = 1'b0;
    stat.is_alloc   = (op == CMD_ALLOC);
    stat.scan_end   = (idx >= count);
    stat.hit        = hit;
    stat.has_prev   = (idx != '0);
    // The allocation has already been carved from cur_size here.
    stat.need_shift = (op == CMD_ALLOC) ? (cur_size == '0)
                    : (merge_both || (!prev_adj && !next_adj));
    stat.shift_end  = (op == CMD_ALLOC || merge_both) ? (sidx + 1'b1 >= count)
                                                      : (sidx <= idx);
    stat.reject     = res_status != ST_OK;
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    waddr = idx[IdxW-1:0];
    wstart = cur_start;
    wsize = cur_size;
    raddr = idx[IdxW-1:0];
    if (ctrl.prev_rd) raddr = IdxW'(idx - 1'b1);
    if (ctrl.shift_rd) begin
      if (op == CMD_ALLOC || merge_both) raddr = IdxW'(sidx + 1'b1);
      else                               raddr = IdxW'(sidx - 1'b1);
    end
    if (ctrl.merge) begin
      we = 1'b1;
      if (op == CMD_ALLOC) begin
        we = hit;
        waddr = idx[IdxW-1:0];
        wstart = cur_start + size;
        wsize = cur_size - size;
      end else if (prev_adj) begin
        waddr = IdxW'(idx - 1'b1);
        wstart = prev_start;
        wsize = merge_both ? prev_size + size + cur_size : prev_size + size;
      end else if (next_adj) begin
        waddr = idx[IdxW-1:0];
        wstart = addr;
        wsize = cur_size + size;
      end else begin
        // Plain insert: the new entry goes in once the tail has moved up.
        we = 1'b0;
      end
    end
    if (ctrl.shift_wr) begin
      we = 1'b1;
      waddr = sidx[IdxW-1:0];
      wstart = rstart;
      wsize = rsize;
    end
    if (ctrl.finish && op != CMD_ALLOC && !prev_adj && !next_adj && res_status == ST_OK) begin
      we = 1'b1;
      waddr = idx[IdxW-1:0];
      wstart = addr;
      wsize = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_size <= '0;
      count <= '0;
      fsum <= '0;
      status <= ST_OK;
      granted_address <= '0;
      free_total <= '0;
      free_entries <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == 1'(REG_POOL_BASE)) pool_base <= cfg_data;
        else                                pool_size <= cfg_data;
      end
      if (ctrl.load) begin
        op <= (cmd == CMD_INIT) ? CMD_FREE : cmd;
        size <= (cmd == CMD_INIT) ? pool_size : sz_in;
        addr <= (cmd == CMD_INIT) ? pool_base : req_address;
        idx <= '0;
        hit <= 1'b0;
        prev_adj <= 1'b0;
        res_grant <= '0;
        res_status <= in_zero ? ST_ZERO : ST_OK;
        if (cmd == CMD_INIT) begin
          count <= '0;
          fsum <= '0;
        end
      end
      if (ctrl.scan_chk) begin
        cur_start <= rstart;
        cur_size <= rsize;
        if (scan_stop) hit <= 1'b1;
        else idx <= idx + 1'b1;
      end
      if (ctrl.prev_chk) begin
        prev_start <= rstart;
        prev_size <= rsize;
        prev_adj <= (rstart + rsize == addr);
      end
      if (ctrl.merge) begin
        if (op == CMD_ALLOC) begin
          if (!hit) res_status <= ST_NOFIT;
          else begin
            res_grant <= cur_start;
            fsum <= fsum - size;
            cur_size <= cur_size - size;
            sidx <= idx;
          end
        end else begin
          if (!prev_adj && !next_adj && count >= CntW'(TableEntries))
            res_status <= ST_FULL;
          else begin
            fsum <= fsum + size;
            sidx <= merge_both ? idx : count;
          end
        end
      end
      if (ctrl.shift_wr) begin
        if (op == CMD_ALLOC || merge_both) sidx <= sidx + 1'b1;
        else                               sidx <= sidx - 1'b1;
      end
      if (ctrl.finish) begin
        if (res_status == ST_OK) begin
          if (op == CMD_ALLOC) begin
            if (cur_size == '0) count <= count - 1'b1;
          end else if (merge_both) count <= count - 1'b1;
          else if (!prev_adj && !next_adj) count <= count + 1'b1;
        end
        status <= res_status;
        granted_address <= (res_status == ST_OK) ? res_grant : '0;
        free_total <= (res_status == ST_OK) ? fsum + 32'd0 : fsum;
        free_entries <= 7'(count);
        if (res_status == ST_OK) begin
          if (op == CMD_ALLOC && cur_size == '0) free_entries <= 7'(count - 1'b1);
          else if (op != CMD_ALLOC && merge_both) free_entries <= 7'(count - 1'b1);
          else if (op != CMD_ALLOC && !prev_adj && !next_adj)
            free_entries <= 7'(count + 1'b1);
        end
      end
    end
  end
endmodule

// ----- design/ffca_ctrl.sv -----
module ffca_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ffca_pkg::stat_t stat,
  output ffca_pkg::ctrl_t ctrl
);
  import ffca_pkg::*;

  state_t state, state_next;
  logic   out_pend;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_SCAN_RD;
      // An allocation scan stops at the first fit; a free scan stops past the address.
      S_SCAN_RD:  state_next = stat.reject ? S_DONE
                             : ((stat.scan_end || stat.hit) ? S_PREV_RD : S_SCAN_CHK);
      S_SCAN_CHK: state_next = S_SCAN_RD;
      S_PREV_RD:  state_next = S_PREV_CHK;
      S_PREV_CHK: state_next = S_MERGE;
      S_MERGE:    state_next = S_SHIFT_RD;
      S_SHIFT_RD: state_next = (stat.reject || !stat.need_shift || stat.shift_end)
                             ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_DONE:     if (!out_pend || !out_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      S_IDLE:     ctrl.load = in_valid;
      S_SCAN_CHK: ctrl.scan_chk = 1'b1;
      S_PREV_RD:  ctrl.prev_rd = 1'b1;
      S_PREV_CHK: ctrl.prev_chk = stat.has_prev && !stat.is_alloc;
      S_MERGE:    ctrl.merge = 1'b1;
      S_SHIFT_RD: ctrl.shift_rd = 1'b1;
      S_SHIFT_WR: ctrl.shift_wr = 1'b1;
      S_DONE:     ctrl.finish = !out_pend || !out_stall;
      default:    ctrl = '0;
    endcase
    ctrl.scan_rd = (state == S_SCAN_RD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.finish) out_pend <= 1'b1;
      else if (!out_stall) out_pend <= 1'b0;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_pend;

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |-> state == S_IDLE) else $error("load outside idle");
  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    out_pend && out_stall |=> out_pend) else $error("result dropped");
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> !(out_pend && out_stall)) else $error("result overwritten");
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ffca_pkg::*;

  typedef struct {
    cmd_t        op;
    logic [31:0] size;
    logic [31:0] addr;
    logic        page;
  } request_t;

  typedef struct {
    status_t     st;
    logic [31:0] granted;
    logic [31:0] total;
    logic [6:0]  entries;
  } outcome_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] size;
  } block_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [31:0] req_size;
  logic [31:0] req_address;
  logic        round_to_page;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] granted_address;
  logic [31:0] free_total;
  logic [6:0]  free_entries;

  first_fit_coalescing_allocator_top dut (.*);

  // Shadow of the free-region table.
  logic [31:0] free_start [TableEntries];
  logic [31:0] free_len [TableEntries];
  int          live_entries;
  logic [31:0] live_bytes;
  logic [31:0] pool_base_q;
  logic [31:0] pool_size_q;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  block_t   held_blocks[$];
  request_t cur_request;
  int       err_count;
  int       queued_items;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       sender_hold;
  bit       hold_start;
  int       hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void drop_entry(int idx);
    live_entries--;
    for (int i = idx; i < live_entries; i++) begin
      free_start[i] = free_start[i + 1];
      free_len[i] = free_len[i + 1];
    end
  endfunction

  function automatic status_t release_region(logic [31:0] a, logic [31:0] s);
    int idx;
    idx = 0;
    if (a == 0 || s == 0) return ST_ZERO;
    while (idx < live_entries && free_start[idx] <= a) idx++;
    if (idx > 0 && free_start[idx - 1] + free_len[idx - 1] == a) begin
      free_len[idx - 1] += s;
      if (idx < live_entries && free_start[idx] == a + s) begin
        free_len[idx - 1] += free_len[idx];
        drop_entry(idx);
      end
      live_bytes += s;
      return ST_OK;
    end
    if (idx < live_entries && free_start[idx] == a + s) begin
      free_start[idx] = a;
      free_len[idx] += s;
      live_bytes += s;
      return ST_OK;
    end
    if (live_entries >= TableEntries) return ST_FULL;
    for (int i = live_entries; i > idx; i--) begin
      free_start[i] = free_start[i - 1];
      free_len[i] = free_len[i - 1];
    end
    free_start[idx] = a;
    free_len[idx] = s;
    live_entries++;
    live_bytes += s;
    return ST_OK;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    logic [32:0] up;
    logic [31:0] sz;
    o.st = ST_NOFIT;
    o.granted = '0;
    sz = r.size;
    if (r.page && r.op != CMD_INIT) begin
      up = {1'b0, sz} + 33'd4095;
      sz = {up[31:12], 12'd0};
    end
    case (r.op)
      CMD_ALLOC: begin
        if (sz == 0) begin
          o.st = ST_ZERO;
        end else begin
          for (int i = 0; i < live_entries; i++) begin
            if (free_len[i] >= sz) begin
              o.granted = free_start[i];
              o.st = ST_OK;
              free_start[i] += sz;
              free_len[i] -= sz;
              live_bytes -= sz;
              if (free_len[i] == 0) drop_entry(i);
              held_blocks.push_back('{o.granted, sz});
              break;
            end
          end
        end
      end
      CMD_FREE: o.st = release_region(r.addr, sz);
      CMD_INIT: begin
        live_entries = 0;
        live_bytes = '0;
        held_blocks.delete();
        o.st = release_region(pool_base_q, pool_size_q);
      end
      default: o.st = ST_ZERO;
    endcase
    o.total = live_bytes;
    o.entries = 7'(live_entries);
    return o;
  endfunction

  // Driver: the payload stays put while the block stalls it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_outcomes.push_back(apply_request(cur_request));
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() > 0 && !sender_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          cur_request = pending_requests.pop_front();
          cmd <= cur_request.op;
          req_size <= cur_request.size;
          req_address <= cur_request.addr;
          round_to_page <= cur_request.page;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_start) hold_left <= 2000;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    err_count++;
  endtask

  // Monitor.
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        report("unexpected transfer", 32'(status), '0);
      end else begin
        e = expected_outcomes.pop_front();
        if (status != e.st) report("status", 32'(status), 32'(e.st));
        if (granted_address != e.granted) report("granted_address", granted_address, e.granted);
        if (free_total != e.total) report("free_total", free_total, e.total);
        if (free_entries != e.entries) report("free_entries", 32'(free_entries), 32'(e.entries));
      end
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic push(cmd_t op, logic [31:0] s, logic [31:0] a, logic p);
    pending_requests.push_back('{op, s, a, p});
    queued_items++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_outcomes.size() > 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r[0];
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    if (r == REG_POOL_BASE) pool_base_q = v;
    else pool_size_q = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic new_pool(logic [31:0] b, logic [31:0] s);
    drain();
    cfg_write(REG_POOL_BASE, b);
    cfg_write(REG_POOL_SIZE, s);
    push(CMD_INIT, $urandom, $urandom, 1'($urandom));
  endtask

  initial begin
    block_t blk;
    logic [31:0] cut;
    logic [31:0] far;
    int kind;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_ALLOC;
    req_size = '0;
    req_address = '0;
    round_to_page = 1'b0;
    out_stall = 1'b0;
    hold_start = 1'b0;
    hold_left = 0;
    sender_hold = 1'b0;
    err_count = 0;
    queued_items = 0;
    send_idle_pct = 29;
    recv_idle_pct = 53;
    live_entries = 0;
    live_bytes = '0;
    pool_base_q = '0;
    pool_size_q = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    push(CMD_ALLOC, 32'd64, '0, 1'b0);
    push(CMD_INIT, '0, '0, 1'b0);
    new_pool(32'h0001_0000, 32'h0010_0000);
    push(CMD_ALLOC, 32'h100, '0, 1'b0);
    push(CMD_ALLOC, 32'h200, '0, 1'b0);
    push(CMD_ALLOC, 32'h300, '0, 1'b0);
    push(CMD_FREE, 32'h100, 32'h0001_0000, 1'b0);
    push(CMD_FREE, 32'h300, 32'h0001_0300, 1'b0);
    push(CMD_FREE, 32'h200, 32'h0001_0100, 1'b0);
    push(CMD_ALLOC, '0, '0, 1'b0);
    push(CMD_ALLOC, 32'd1, '0, 1'b1);
    push(CMD_ALLOC, 32'hFFFF_FFFF, '0, 1'b1);
    push(CMD_ALLOC, 32'hFFFF_FFFF, '0, 1'b0);
    push(CMD_FREE, 32'h10, '0, 1'b0);
    push(CMD_FREE, '0, 32'h1000_0000, 1'b0);
    push(CMD_FREE, 32'h10, 32'h1000_0000, 1'b0);
    push(CMD_FREE, 32'h10, 32'h1000_0010, 1'b0);
    push(CMD_FREE, 32'h20, 32'hFFFF_FFF0, 1'b0);
    push(CMD_FREE, 32'h7FF, 32'h2000_0000, 1'b1);
    push(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push(CMD_ALLOC, 32'h0010_0000, '0, 1'b0);
    new_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    new_pool(32'h0000_1000, '0);

    // Block fills up while the receiver holds off for a long stretch.
    new_pool(32'h0000_4000, 32'h0004_0000);
    for (int i = 0; i < 24; i++) push(CMD_ALLOC, $urandom_range(1, 32'h2000), '0, 1'($urandom));
    @(negedge clk);
    hold_start = 1'b1;
    @(negedge clk);
    hold_start = 1'b0;
    drain();

    // The sender pauses until everything has come back.
    for (int i = 0; i < 10; i++) push(CMD_ALLOC, $urandom_range(1, 32'h800), '0, 1'b0);
    do @(posedge clk);
    while (pending_requests.size() >= 5);
    sender_hold = 1'b1;
    do @(posedge clk);
    while (in_valid || expected_outcomes.size() > 0);
    sender_hold = 1'b0;
    drain();

    while (queued_items < 950) begin
      if (queued_items < 320) begin
        send_idle_pct = 29;
        recv_idle_pct = 53;
      end else if (queued_items < 640) begin
        send_idle_pct = 53;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      kind = $urandom_range(99);
      if (kind < 8) begin
        new_pool($urandom_range(1, 32'h00FF_FFFF) << 4, $urandom_range(32'h1000, 32'h0010_0000));
      end else if (kind < 13) begin
        // Scattered frees far from the pool run the table into its limit.
        far = 32'hC000_0000 + ($urandom_range(255) << 16);
        for (int i = 0; i < TableEntries + 2; i++)
          push(CMD_FREE, 32'h1000, far + 32'h2000 * i, 1'b0);
      end else if (kind < 23) begin
        for (int i = 0; i < 8; i++)
          push(cmd_t'($urandom_range(3)), $urandom_range(1) ? $urandom : $urandom_range(15),
               $urandom, 1'($urandom));
      end else begin
        for (int i = 0; i < 16; i++) begin
          if (held_blocks.size() > 0 && $urandom_range(1)) begin
            blk = held_blocks[0];
            held_blocks.delete(0);
            if (blk.size > 1 && $urandom_range(2) == 0) begin
              cut = $urandom_range(1, blk.size - 1);
              push(CMD_FREE, blk.size - cut, blk.addr + cut, 1'b0);
              push(CMD_FREE, cut, blk.addr, 1'b0);
            end else begin
              push(CMD_FREE, blk.size, blk.addr, 1'b0);
            end
          end else begin
            push(CMD_ALLOC, $urandom_range(1, 32'h3000), '0, $urandom_range(3) == 0);
          end
        end
      end
      drain();
      // Shuffle the queue of blocks so frees land out of order.
      if (held_blocks.size() > 1) held_blocks.shuffle();
    end

    drain();
    repeat (300) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_top failed");
    $finish;
  end
endmodule

// ----- sim.f -----
design/ffca_pkg.sv
design/ffca_ram.sv
design/ffca_datapath.sv
design/ffca_ctrl.sv
design/first_fit_coalescing_allocator_top.sv
tb/tb_top.sv
